### hw/rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define LGT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define LGT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### hw/rtl/lgt_pkg.sv
// Shared types and constants for the toroidal life generation block.
`timescale 1ns / 1ps

package lgt_pkg;

    // Default grid size.
    localparam int GRID_ROWS_DEF = 8;
    localparam int GRID_COLS_DEF = 8;

    // Fixed payload field widths.
    localparam int OPCODE_W  = 2;
    localparam int ROW_IDX_W = 3;
    localparam int CELLS_W   = 8;

    // Neighbor counts of the rules: birth on three, survival also on two.
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    // Command codes; code 3 is unused and ignored.
    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD = 2'd0,
        OP_STEP = 2'd1,
        OP_SHOW = 2'd2
    } opcode_t;

endpackage

### hw/rtl/lgt_in_if.sv
// Command channel: valid/ready handshake carrying one command per transfer.
`timescale 1ns / 1ps

interface lgt_in_if;
    import lgt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OPCODE_W-1:0]  opcode;
    logic [ROW_IDX_W-1:0] row_index;
    logic [CELLS_W-1:0]   row_bits;

    modport source (output valid, output opcode, output row_index, output row_bits,
                    input ready);
    modport sink   (input valid, input opcode, input row_index, input row_bits,
                    output ready);
    modport mon    (input valid, input ready, input opcode, input row_index,
                    input row_bits);
endinterface

### hw/rtl/lgt_out_if.sv
// Result channel: valid/ready handshake carrying one grid row per transfer.
`timescale 1ns / 1ps

interface lgt_out_if;
    import lgt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ROW_IDX_W-1:0] out_row;
    logic [CELLS_W-1:0]   out_cells;
    logic                 last_row;
    logic                 stable;

    modport source (output valid, output out_row, output out_cells, output last_row,
                    output stable, input ready);
    modport sink   (input valid, input out_row, input out_cells, input last_row,
                    input stable, output ready);
    modport mon    (input valid, input ready, input out_row, input out_cells,
                    input last_row, input stable);
endinterface

### hw/rtl/lgt_row_unit.sv
// Shared row unit: next generation of one row from the row and its two neighbors.
`timescale 1ns / 1ps

module lgt_row_unit #(
    parameter int COLS = lgt_pkg::GRID_COLS_DEF
) (
    input  logic [COLS-1:0] up_row,
    input  logic [COLS-1:0] cur_row,
    input  logic [COLS-1:0] dn_row,
    output logic [COLS-1:0] new_row
);
    import lgt_pkg::*;

    logic [3:0] live_cnt [COLS];

    // Each column counts its eight neighbors with wrap-around at the row ends.
    always_comb
    begin
        for (int c = 0; c < COLS; c++)
        begin
            live_cnt[c] = 4'(up_row[(c + COLS - 1) % COLS]) + 4'(up_row[c])
                        + 4'(up_row[(c + 1) % COLS])
                        + 4'(cur_row[(c + COLS - 1) % COLS]) + 4'(cur_row[(c + 1) % COLS])
                        + 4'(dn_row[(c + COLS - 1) % COLS]) + 4'(dn_row[c])
                        + 4'(dn_row[(c + 1) % COLS]);
            new_row[c] = (live_cnt[c] == BIRTH_COUNT)
                       | (cur_row[c] & (live_cnt[c] == SURVIVE_COUNT));
        end
    end

endmodule

### hw/rtl/life_generation_torus.sv
// Top level of the toroidal life generation block: grid storage and sequencer.
`timescale 1ns / 1ps

// Holds a GRID_ROWS x GRID_COLS grid of cells with wrap-around edges. A load produces no
// output. A step runs the single row unit once per row while the grid rotates past it,
// commits the new generation in S_COMMIT, then emits one row per cycle whenever the
// output register is free. A show emits the grid the same way; output stalls hold the
// emission back. Ready is low while a step or show runs; the last row may still sit in
// the output register when the next command is taken. Every step reports on all its
// rows whether the new grid equals the previous one.
module life_generation_torus #(
    parameter int GRID_ROWS = lgt_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = lgt_pkg::GRID_COLS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    lgt_in_if.sink    in_ch,
    lgt_out_if.source out_ch
);
    import lgt_pkg::*;

    localparam int IDX_W   = $clog2(GRID_ROWS);
    localparam int RIDX_W  = IDX_W + ROW_IDX_W;
    localparam int CEXT_W  = GRID_COLS + CELLS_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GRID_ROWS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_COMMIT,
        S_EMIT
    } state_t;

    typedef logic [GRID_COLS-1:0] row_t;

    state_t               state_reg, state_next;
    row_t                 grid_reg [GRID_ROWS];
    row_t                 grid_next [GRID_ROWS];
    row_t                 gen_reg [GRID_ROWS];
    row_t                 gen_next [GRID_ROWS];
    logic [IDX_W-1:0]     cnt_reg, cnt_next;
    logic                 same_reg, same_next;
    logic                 out_valid_reg, out_valid_next;
    logic [ROW_IDX_W-1:0] out_row_reg, out_row_next;
    logic [CELLS_W-1:0]   out_cells_reg, out_cells_next;
    logic                 last_reg, last_next;
    logic                 stable_reg, stable_next;

    row_t                 calc_row;
    row_t                 load_row;
    logic [RIDX_W-1:0]    cnt_ext;
    logic [RIDX_W-1:0]    idx_ext;
    logic [CEXT_W-1:0]    cells_ext;
    logic [CEXT_W-1:0]    load_ext;
    logic                 in_xfer;
    logic                 emit_slot;

    // The row under work always sits at position 0; its neighbors at position 1 and at the last position.
    lgt_row_unit #(
        .COLS (GRID_COLS)
    ) u_row_unit (
        .up_row  (grid_reg[GRID_ROWS-1]),
        .cur_row (grid_reg[0]),
        .dn_row  (grid_reg[1]),
        .new_row (calc_row)
    );

    // Width adaptation between the grid size and the fixed payload fields.
    assign cnt_ext   = {{ROW_IDX_W{1'b0}}, cnt_reg};
    assign idx_ext   = {{IDX_W{1'b0}}, in_ch.row_index};
    assign cells_ext = {{CELLS_W{1'b0}}, grid_reg[0]};
    assign load_ext  = {{GRID_COLS{1'b0}}, in_ch.row_bits};
    assign load_row  = load_ext[GRID_COLS-1:0];

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_xfer     = in_ch.valid & in_ch.ready;
    assign emit_slot   = !out_valid_reg || out_ch.ready;

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_row   = out_row_reg;
    assign out_ch.out_cells = out_cells_reg;
    assign out_ch.last_row  = last_reg;
    assign out_ch.stable    = stable_reg;

    // Sequencer next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        grid_next      = grid_reg;
        gen_next       = gen_reg;
        cnt_next       = cnt_reg;
        same_next      = same_reg;
        out_valid_next = out_valid_reg;
        out_row_next   = out_row_reg;
        out_cells_next = out_cells_reg;
        last_next      = last_reg;
        stable_next    = stable_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    unique case (in_ch.opcode)
                        OP_LOAD:
                        begin
                            if (idx_ext < RIDX_W'(GRID_ROWS))
                            begin
                                grid_next[idx_ext[IDX_W-1:0]] = load_row;
                            end
                        end
                        OP_STEP:
                        begin
                            cnt_next   = '0;
                            same_next  = 1'b1;
                            state_next = S_CALC;
                        end
                        OP_SHOW:
                        begin
                            cnt_next   = '0;
                            same_next  = 1'b0;
                            state_next = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_CALC:
            begin
                // New rows shift into the generation line; the grid rotates by one row.
                for (int i = 0; i < GRID_ROWS - 1; i++)
                begin
                    gen_next[i] = gen_reg[i + 1];
                end
                gen_next[GRID_ROWS-1] = calc_row;
                for (int i = 0; i < GRID_ROWS; i++)
                begin
                    grid_next[i] = grid_reg[(i + 1) % GRID_ROWS];
                end
                if (calc_row != grid_reg[0])
                begin
                    same_next = 1'b0;
                end
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = S_COMMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end

            S_COMMIT:
            begin
                grid_next  = gen_reg;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                // One row goes to the output register whenever it is free.
                if (emit_slot)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = cnt_ext[ROW_IDX_W-1:0];
                    out_cells_next = cells_ext[CELLS_W-1:0];
                    last_next      = (cnt_reg == LAST_IDX);
                    stable_next    = same_reg;
                    for (int i = 0; i < GRID_ROWS; i++)
                    begin
                        grid_next[i] = grid_reg[(i + 1) % GRID_ROWS];
                    end
                    if (cnt_reg == LAST_IDX)
                    begin
                        cnt_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + IDX_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, grid and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            same_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_row_reg   <= '0;
            out_cells_reg <= '0;
            last_reg      <= 1'b0;
            stable_reg    <= 1'b0;
            for (int i = 0; i < GRID_ROWS; i++)
            begin
                grid_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            same_reg      <= same_next;
            out_valid_reg <= out_valid_next;
            out_row_reg   <= out_row_next;
            out_cells_reg <= out_cells_next;
            last_reg      <= last_next;
            stable_reg    <= stable_next;
            grid_reg      <= grid_next;
        end
    end

    // The generation line is always written before it is read.
    always_ff @(posedge clk)
    begin
        gen_reg <= gen_next;
    end

endmodule

### hw/rtl/lgt_checker.sv
// Port-level checker for the toroidal life generation block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lgt_checker (
    input logic       clk,
    input logic       rst_n,
    lgt_in_if.sink    in_ch,
    lgt_out_if.source out_ch
);
    import lgt_pkg::*;

    logic in_xfer;

    assign in_xfer = in_ch.valid && in_ch.ready;

    // A load completes at once, so the next command can follow directly.
    `LGT_ASSERT_NEXT(a_load_ready, in_xfer && (in_ch.opcode == OP_LOAD), in_ch.ready)

    // A step keeps the command side closed while it works.
    `LGT_ASSERT_NEXT(a_step_busy, in_xfer && (in_ch.opcode == OP_STEP), !in_ch.ready)

    // While a row other than the last one is offered, the grid is still being emitted.
    `LGT_ASSERT_NOW(a_emit_busy, out_ch.valid && !out_ch.last_row, !in_ch.ready)

    // A stalled result holds its payload.
    `LGT_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready,
        out_ch.valid && $stable(out_ch.out_row) && $stable(out_ch.out_cells)
        && $stable(out_ch.last_row) && $stable(out_ch.stable))

endmodule

bind life_generation_torus lgt_checker u_lgt_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
);

### dv/life_generation_torus_tb.sv
// Self-checking testbench for the toroidal life generation block.
`timescale 1ns / 1ps

module life_generation_torus_tb;
    import lgt_pkg::*;

    localparam int ROWS        = GRID_ROWS_DEF;
    localparam int COLS        = GRID_COLS_DEF;
    localparam int CLK_HALF    = 5;
    localparam int ITEM_TARGET = 480;
    localparam int HOLD_CYCLES = 90;
    localparam int TIMEOUT_NS  = 5_000_000;

    // Opcode value that the block ignores.
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    // One expected output row.
    typedef struct packed {
        logic [ROW_IDX_W-1:0] row;
        logic [CELLS_W-1:0]   cells;
        logic                 last;
        logic                 stable;
    } row_expect_t;

    // One directed command; typed rows carry the uniform value that every output row shows.
    typedef struct packed {
        logic [OPCODE_W-1:0]  op;
        logic [ROW_IDX_W-1:0] idx;
        logic [CELLS_W-1:0]   bits;
        logic                 typed;
        logic [CELLS_W-1:0]   cells;
        logic                 stable;
    } script_row_t;

    localparam script_row_t SCRIPT [22] = '{
        // Fresh grid is empty, and an empty grid is a still life.
        '{OP_SHOW,   3'd5, 8'hA5, 1'b1, 8'h00, 1'b0},
        '{OP_STEP,   3'd2, 8'h3C, 1'b1, 8'h00, 1'b1},
        // Fill every cell; each then has eight live neighbors and dies.
        '{OP_LOAD,   3'd0, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{OP_LOAD,   3'd1, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{OP_LOAD,   3'd2, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{OP_LOAD,   3'd3, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{OP_LOAD,   3'd4, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{OP_LOAD,   3'd5, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{OP_LOAD,   3'd6, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{OP_LOAD,   3'd7, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{OP_SHOW,   3'd0, 8'h00, 1'b1, 8'hFF, 1'b0},
        '{OP_STEP,   3'd7, 8'hFF, 1'b1, 8'h00, 1'b0},
        // The unused opcode must leave the grid alone and emit nothing.
        '{OP_UNUSED, 3'd7, 8'hFF, 1'b0, 8'h00, 1'b0},
        // Blinker that wraps across the column edge, then across the row edge.
        '{OP_LOAD,   3'd0, 8'h83, 1'b0, 8'h00, 1'b0},
        '{OP_STEP,   3'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{OP_STEP,   3'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{OP_SHOW,   3'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        // Clear the blinker and leave a block, which is stable.
        '{OP_LOAD,   3'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{OP_LOAD,   3'd4, 8'h18, 1'b0, 8'h00, 1'b0},
        '{OP_LOAD,   3'd5, 8'h18, 1'b0, 8'h00, 1'b0},
        '{OP_STEP,   3'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{OP_STEP,   3'd0, 8'h00, 1'b0, 8'h00, 1'b0}
    };

    logic clk;
    logic rst_n;

    lgt_in_if  in_ch ();
    lgt_out_if out_ch ();

    life_generation_torus dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Predicted grid and the rows it still owes.
    logic [CELLS_W-1:0] board [ROWS];
    row_expect_t        pending_rows [$];
    int                 mismatches = 0;
    int                 items_sent = 0;
    bit                 steady     = 1'b0;
    bit                 hold_now   = 1'b0;

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    initial
    begin
        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("life_generation_torus: mismatch");
        $finish;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    function automatic void flag_error(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    // Advance the predicted grid one generation on the torus.
    function automatic void next_generation(output bit same);
        logic [CELLS_W-1:0] nxt [ROWS];
        int                 live;
        bit                 alive;
        same = 1'b1;
        for (int r = 0; r < ROWS; r++)
        begin
            nxt[r] = '0;
            for (int c = 0; c < COLS; c++)
            begin
                live = 0;
                for (int dr = -1; dr <= 1; dr++)
                    for (int dc = -1; dc <= 1; dc++)
                        if (dr != 0 || dc != 0)
                            live += int'(board[(r + dr + ROWS) % ROWS][(c + dc + COLS) % COLS]);
                alive = board[r][c];
                nxt[r][c] = (live == BIRTH_COUNT) || (alive && live == SURVIVE_COUNT);
            end
            if (nxt[r] != board[r])
                same = 1'b0;
        end
        for (int r = 0; r < ROWS; r++)
            board[r] = nxt[r];
    endfunction

    // Apply one accepted command to the predicted grid and queue the rows it emits.
    function automatic void record_cmd(logic [OPCODE_W-1:0] op, logic [ROW_IDX_W-1:0] idx,
                                       logic [CELLS_W-1:0] bits, logic typed,
                                       logic [CELLS_W-1:0] gold_cells, logic gold_stable);
        bit same;
        same = 1'b0;
        if (op == OP_LOAD)
            board[idx] = bits;
        if (op == OP_STEP)
            next_generation(same);
        if (op == OP_STEP || op == OP_SHOW)
        begin
            for (int r = 0; r < ROWS; r++)
                pending_rows.push_back('{ROW_IDX_W'(r),
                                         typed ? gold_cells : board[r],
                                         r == ROWS - 1,
                                         typed ? gold_stable : (op == OP_STEP && same)});
        end
    endfunction

    // Offer one command, wait for its transfer, then record what it should produce.
    task automatic send_cmd(input logic [OPCODE_W-1:0] op, input logic [ROW_IDX_W-1:0] idx,
                            input logic [CELLS_W-1:0] bits, input logic typed = 1'b0,
                            input logic [CELLS_W-1:0] gold_cells = '0,
                            input logic gold_stable = 1'b0);
        int gap;
        gap = steady ? 0 : gap_length();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.opcode    <= op;
        in_ch.row_index <= idx;
        in_ch.row_bits  <= bits;
        do
            @(posedge clk);
        while (!in_ch.ready);
        record_cmd(op, idx, bits, typed, gold_cells, gold_stable);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    // Result side: random ready with runs, plus one long hold-off on request.
    initial
    begin : result_sink
        int  sink_run;
        int  sink_hold;
        bit  sink_level;
        sink_run   = 0;
        sink_hold  = 0;
        sink_level = 1'b0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_now)
            begin
                hold_now  = 1'b0;
                sink_hold = HOLD_CYCLES;
            end
            if (sink_hold > 0)
            begin
                sink_hold--;
                out_ch.ready <= 1'b0;
            end
            else if (steady)
                out_ch.ready <= 1'b1;
            else
            begin
                if (sink_run == 0)
                begin
                    sink_level = !sink_level;
                    sink_run   = sink_level ? $urandom_range(1, 12) : gap_length() + 1;
                end
                sink_run--;
                out_ch.ready <= sink_level;
            end
        end
    end

    // Compare every transferred row against the oldest expectation.
    always @(posedge clk)
    begin : row_check
        row_expect_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_rows.size() == 0)
                flag_error($sformatf("unexpected row %0d cells %h", out_ch.out_row,
                                     out_ch.out_cells));
            else
            begin
                want = pending_rows.pop_front();
                if (out_ch.out_row !== want.row)
                    flag_error($sformatf("out_row exp %0d got %0d", want.row, out_ch.out_row));
                if (out_ch.out_cells !== want.cells)
                    flag_error($sformatf("row %0d out_cells exp %h got %h", want.row,
                                         want.cells, out_ch.out_cells));
                if (out_ch.last_row !== want.last)
                    flag_error($sformatf("row %0d last_row exp %b got %b", want.row,
                                         want.last, out_ch.last_row));
                if (out_ch.stable !== want.stable)
                    flag_error($sformatf("row %0d stable exp %b got %b", want.row,
                                         want.stable, out_ch.stable));
            end
        end
    end

    // Command side: directed walk, then random seeded runs of generations.
    initial
    begin : stimulus
        logic [CELLS_W-1:0] pat [3];
        logic [CELLS_W-1:0] rowv;
        int                 pat_rows;
        int                 base;
        int                 shift;
        int                 n_steps;
        bit                 pressure_done;
        bit                 pause_done;
        pressure_done = 1'b0;
        pause_done    = 1'b0;
        for (int r = 0; r < ROWS; r++)
            board[r] = '0;
        in_ch.valid     <= 1'b0;
        in_ch.opcode    <= OP_LOAD;
        in_ch.row_index <= '0;
        in_ch.row_bits  <= '0;
        @(posedge rst_n);
        @(posedge clk);

        foreach (SCRIPT[i])
            send_cmd(SCRIPT[i].op, SCRIPT[i].idx, SCRIPT[i].bits, SCRIPT[i].typed,
                     SCRIPT[i].cells, SCRIPT[i].stable);

        while (items_sent < ITEM_TARGET)
        begin
            steady = ($urandom_range(0, 5) == 0);

            // Block the result side while steps keep coming, so the input stalls.
            if (!pressure_done && items_sent > 150)
            begin
                pressure_done = 1'b1;
                steady        = 1'b1;
                hold_now      = 1'b1;
                repeat (5)
                    send_cmd(OP_STEP, ROW_IDX_W'($urandom_range(0, 7)),
                             CELLS_W'($urandom_range(0, 255)));
                steady = 1'b0;
            end

            // Let the block drain completely before going on.
            if (!pause_done && items_sent > 320)
            begin
                pause_done = 1'b1;
                in_ch.valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_rows.size() != 0);
            end

            if ($urandom_range(0, 99) < 75)
            begin
                // Seed the grid one way or another, then watch it evolve.
                case ($urandom_range(0, 3))
                    0:
                    begin
                        for (int r = 0; r < ROWS; r++)
                            send_cmd(OP_LOAD, ROW_IDX_W'(r), CELLS_W'($urandom_range(0, 255)));
                    end
                    1:
                    begin
                        for (int r = 0; r < ROWS; r++)
                            send_cmd(OP_LOAD, ROW_IDX_W'(r),
                                     CELLS_W'($urandom_range(0, 255) & $urandom_range(0, 255)));
                    end
                    2:
                    begin
                        case ($urandom_range(0, 2))
                            0:
                            begin
                                pat[0] = 8'h02;
                                pat[1] = 8'h04;
                                pat[2] = 8'h07;
                                pat_rows = 3;
                            end
                            1:
                            begin
                                pat[0] = 8'h07;
                                pat_rows = 1;
                            end
                            default:
                            begin
                                pat[0] = 8'h03;
                                pat[1] = 8'h03;
                                pat_rows = 2;
                            end
                        endcase
                        base  = $urandom_range(0, ROWS - 1);
                        shift = $urandom_range(0, COLS - 1);
                        for (int r = 0; r < ROWS; r++)
                            send_cmd(OP_LOAD, ROW_IDX_W'(r), 8'h00);
                        for (int k = 0; k < pat_rows; k++)
                        begin
                            rowv = (pat[k] << shift) | (pat[k] >> (COLS - shift));
                            send_cmd(OP_LOAD, ROW_IDX_W'((base + k) % ROWS), rowv);
                        end
                    end
                    default:
                    begin
                        repeat ($urandom_range(1, 3))
                            send_cmd(OP_LOAD, ROW_IDX_W'($urandom_range(0, 7)),
                                     CELLS_W'($urandom_range(0, 255)));
                    end
                endcase
                n_steps = $urandom_range(1, 6);
                repeat (n_steps)
                begin
                    send_cmd(OP_STEP, ROW_IDX_W'($urandom_range(0, 7)),
                             CELLS_W'($urandom_range(0, 255)));
                    if ($urandom_range(0, 4) == 0)
                        send_cmd(OP_SHOW, ROW_IDX_W'($urandom_range(0, 7)),
                                 CELLS_W'($urandom_range(0, 255)));
                end
            end
            else
            begin
                // Noise: any opcode with any fields.
                repeat ($urandom_range(1, 4))
                    send_cmd(OPCODE_W'($urandom_range(0, 3)), ROW_IDX_W'($urandom_range(0, 7)),
                             CELLS_W'($urandom_range(0, 255)));
            end
        end
        in_ch.valid <= 1'b0;
        steady = 1'b0;

        // Wait for every owed row, then give stray output a chance to show up.
        do
            @(posedge clk);
        while (pending_rows.size() != 0);
        repeat (4 * ROWS + 4) @(posedge clk);

        if (mismatches == 0)
            $display("life_generation_torus: match");
        else
            $display("life_generation_torus: mismatch");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/lgt_pkg.sv
hw/rtl/lgt_in_if.sv
hw/rtl/lgt_out_if.sv
hw/rtl/lgt_row_unit.sv
hw/rtl/life_generation_torus.sv
hw/rtl/lgt_checker.sv
dv/life_generation_torus_tb.sv
